### rtl/core/lpe_pkg.sv
// Shared types, constants and the dictionary hash for the LZW pixel encoder.
// No dependencies; lpe_out_reg and the top level take names from here by scope.
package lpe_pkg;

    localparam int DICT_AW    = 13;
    localparam int DICT_DEPTH = 1 << DICT_AW;

    localparam logic [12:0] CODE_LIMIT = 13'd4093;
    localparam logic [3:0]  MAX_WIDTH  = 4'd12;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_PIXEL  = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // One dictionary word: valid flag, prefix code, pixel, assigned code.
    typedef struct packed {
        logic        valid;
        logic [11:0] prefix;
        logic [7:0]  pixel;
        logic [11:0] code;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Result handed from the sequencer to the output stage.
    typedef struct packed {
        logic        valid;
        logic [11:0] code;
        logic [3:0]  width;
        logic        last;
    } res_t;

    // Probe start: ((prefix*263) ^ (pixel*40503)) modulo the table depth.
    function automatic logic [DICT_AW-1:0] hash(input logic [11:0] prefix,
                                               input logic [7:0] pix);
        logic [24:0] a;
        logic [24:0] b;
        begin
            a = 25'(prefix) * 25'd263;
            b = 25'(pix) * 25'd40503;
            return a[DICT_AW-1:0] ^ b[DICT_AW-1:0];
        end
    endfunction

endpackage

### rtl/core/lpe_cmd_if.sv
// Command channel: valid/ready handshake carrying command and pixel.
// Depends on nothing.
interface lpe_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] pixel;

    modport source (output valid, output command, output pixel, input ready);
    modport sink   (input valid, input command, input pixel, output ready);
endinterface

### rtl/core/lpe_code_if.sv
// Code channel: valid/ready handshake carrying code, code_width and last.
// Depends on nothing.
interface lpe_code_if;
    logic        valid;
    logic        ready;
    logic [11:0] code;
    logic [3:0]  code_width;
    logic        last;

    modport source (output valid, output code, output code_width, output last, input ready);
    modport sink   (input valid, input code, input code_width, input last, output ready);
endinterface

### rtl/core/lpe_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lpe_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/lpe_out_reg.sv
// Output register stage of the encoder: holds one code transaction.
// Depends on lpe_pkg and lpe_code_if.
module lpe_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  lpe_pkg::res_t      res,
    output logic               take,
    lpe_code_if.source         codes
);

    logic        vld_reg;
    logic [11:0] code_reg;
    logic [3:0]  width_reg;
    logic        last_reg;

    assign take = !vld_reg || codes.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (take)
        begin
            vld_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res.valid)
        begin
            code_reg  <= res.code;
            width_reg <= res.width;
            last_reg  <= res.last;
        end
    end

    assign codes.valid      = vld_reg;
    assign codes.code       = code_reg;
    assign codes.code_width = width_reg;
    assign codes.last       = last_reg;

endmodule

### rtl/core/lzw_pixel_encoder_unit.sv
// LZW pixel encoder top level: sequencer, dictionary RAM and output stage.
// Depends on lpe_pkg, lpe_cmd_if, lpe_code_if, lpe_ram and lpe_out_reg.
//
// GIF-style LZW code generator. Each command transaction (start, pixel,
// finish) yields zero to three code transactions, the final one flagged with
// last. The dictionary lives in one 8192 x 33 synchronous RAM probed by
// linear hashing: a pixel that extends a pending string is accepted, then
// probed, each probe a read (S_READ) followed by a compare (S_CHECK); the
// first pixel of a string needs no lookup. Each emitted code then passes
// through S_EMIT and the output register. One command is worked on at a time.
// After reset, after every start command and after every automatic restart
// the RAM is swept clean, one entry per cycle over all 8192 entries, during
// which no command is taken (pixel_bits writes are still taken). pixel_bits
// should be written only while the block is idle.
module lzw_pixel_encoder_unit #(
    parameter int MAX_STRING   = 100,
    parameter int STRING_SPACE = 64000,
    parameter int ENTRY_SLOTS  = 5003
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata,
    lpe_cmd_if.sink    cmd,
    lpe_code_if.source codes
);

    localparam int AW = lpe_pkg::DICT_AW;
    localparam int ENTRY_W_L = lpe_pkg::ENTRY_W;
    localparam logic [7:0]  LenLimit  = 8'(MAX_STRING - 3);
    localparam logic [12:0] RealLimit = 13'((ENTRY_SLOTS * 2) / 3);
    localparam logic [16:0] ByteLimit = 17'(STRING_SPACE - MAX_STRING - 5);
    localparam logic [AW-1:0] LastAddr = {AW{1'b1}};

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_CHECK = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [3:0]    pbits_reg;
    logic [11:0]   cur_reg, cur_next;
    logic [6:0]    len_reg, len_next;
    logic [11:0]   used_reg, used_next;
    logic [11:0]   real_reg, real_next;
    logic [15:0]   bytes_reg, bytes_next;
    logic [3:0]    width_reg, width_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] probe_reg, probe_next;
    logic [7:0]    pix_reg, pix_next;
    logic [1:0]    idx_reg, idx_next;
    logic [1:0]    lastidx_reg, lastidx_next;
    logic          wipe_reg, wipe_next;
    logic [11:0]   rcode_reg [3];
    logic [11:0]   rcode_next [3];
    logic [3:0]    rwidth_reg [3];
    logic [3:0]    rwidth_next [3];

    // Derived from pixel_bits; the user must keep it fixed while an item is in progress, the block does not enforce it.
    logic [3:0]  eff;
    logic [3:0]  sw;
    logic [11:0] clear_code;
    logic [11:0] end_code;
    logic [7:0]  pix_mask;
    logic [7:0]  pix_in;

    // Probe and update terms.
    lpe_pkg::entry_t rd_entry;
    lpe_pkg::entry_t wr_entry;
    logic [ENTRY_W_L-1:0] rd_data;
    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    logic        ram_re;
    logic        hit;
    logic        miss;
    logic [7:0]  len_inc;
    logic [11:0] used_n;
    logic [12:0] next_code;
    logic [11:0] real_n;
    logic [16:0] bytes_n;
    logic        grow;
    logic [3:0]  width_n;
    logic        restart;

    lpe_pkg::res_t res;
    logic          take;

    // Clamp pixel_bits to 1..8; one bit per pixel still starts at width 3.
    always_comb
    begin
        if (pbits_reg == 4'd0)
        begin
            eff = 4'd1;
        end
        else if (pbits_reg > 4'd8)
        begin
            eff = 4'd8;
        end
        else
        begin
            eff = pbits_reg;
        end
    end

    assign sw         = (eff == 4'd1) ? 4'd3 : eff + 4'd1;
    assign clear_code = 12'd1 << (sw - 4'd1);
    assign end_code   = clear_code + 12'd1;
    assign pix_mask   = 8'((9'd1 << eff) - 9'd1);
    assign pix_in     = cmd.pixel & pix_mask;

    assign rd_entry = lpe_pkg::entry_t'(rd_data);
    assign hit      = rd_entry.valid && (rd_entry.prefix == cur_reg)
                      && (rd_entry.pixel == pix_reg);
    assign miss     = !rd_entry.valid;
    assign len_inc  = {1'b0, len_reg} + 8'd1;

    // Bookkeeping once a code goes out; entry added only on a miss.
    assign used_n    = used_reg + 12'd1;
    assign next_code = {1'b0, used_n} + {1'b0, end_code};
    assign real_n    = miss ? real_reg + 12'd1 : real_reg;
    assign bytes_n   = miss ? 17'(bytes_reg) + 17'(len_reg) + 17'd4 : 17'(bytes_reg);
    assign grow      = (width_reg < lpe_pkg::MAX_WIDTH)
                       && (next_code == (13'd1 << width_reg));
    assign width_n   = grow ? width_reg + 4'd1 : width_reg;
    assign restart   = (next_code > lpe_pkg::CODE_LIMIT)
                       || ({1'b0, real_n} > RealLimit)
                       || (bytes_n > ByteLimit);

    always_comb
    begin
        wr_entry.valid  = 1'b1;
        wr_entry.prefix = cur_reg;
        wr_entry.pixel  = pix_reg;
        wr_entry.code   = next_code[11:0];
    end

    assign cmd.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        len_next     = len_reg;
        used_next    = used_reg;
        real_next    = real_reg;
        bytes_next   = bytes_reg;
        width_next   = width_reg;
        clr_next     = clr_reg;
        probe_next   = probe_reg;
        pix_next     = pix_reg;
        idx_next     = idx_reg;
        lastidx_next = lastidx_reg;
        wipe_next    = wipe_reg;
        rcode_next   = rcode_reg;
        rwidth_next  = rwidth_reg;
        ram_we       = 1'b0;
        ram_waddr    = probe_reg;
        ram_re       = 1'b0;
        res.valid    = 1'b0;
        res.code     = rcode_reg[idx_reg];
        res.width    = rwidth_reg[idx_reg];
        res.last     = (idx_reg == lastidx_reg);

        case (state_reg)
            S_CLEAR:
            begin
                // Sweep the dictionary, one entry per cycle.
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LastAddr)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    idx_next = 2'd0;
                    case (lpe_pkg::cmd_t'(cmd.command))
                        lpe_pkg::CMD_START:
                        begin
                            // Clear code, then empty the table.
                            rcode_next[0]  = clear_code;
                            rwidth_next[0] = sw;
                            lastidx_next   = 2'd0;
                            wipe_next      = 1'b1;
                            used_next      = '0;
                            real_next      = '0;
                            bytes_next     = 16'd1;
                            len_next       = '0;
                            width_next     = sw;
                            state_next     = S_EMIT;
                        end
                        lpe_pkg::CMD_FINISH:
                        begin
                            // Flush the pending string if any, then the end code.
                            wipe_next = 1'b0;
                            if (len_reg != '0)
                            begin
                                rcode_next[0]  = cur_reg;
                                rwidth_next[0] = width_reg;
                                rcode_next[1]  = end_code;
                                rwidth_next[1] = width_reg;
                                lastidx_next   = 2'd1;
                            end
                            else
                            begin
                                rcode_next[0]  = end_code;
                                rwidth_next[0] = width_reg;
                                lastidx_next   = 2'd0;
                            end
                            len_next   = '0;
                            state_next = S_EMIT;
                        end
                        lpe_pkg::CMD_PIXEL:
                        begin
                            if (len_reg == '0)
                            begin
                                // First pixel of a string: no lookup.
                                cur_next = 12'(pix_in);
                                len_next = 7'd1;
                            end
                            else
                            begin
                                pix_next   = pix_in;
                                probe_next = lpe_pkg::hash(cur_reg, pix_in);
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            // Unused command: drop it.
                        end
                    endcase
                end
            end
            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (rd_entry.valid && !hit)
                begin
                    // Occupied by another string: advance to the next slot.
                    probe_next = probe_reg + 1'b1;
                    state_next = S_READ;
                end
                else if (hit && (len_inc < LenLimit))
                begin
                    cur_next   = rd_entry.code;
                    len_next   = len_inc[6:0];
                    state_next = S_IDLE;
                end
                else
                begin
                    // Emit the pending code; add an entry on a miss.
                    ram_we         = miss;
                    rcode_next[0]  = cur_reg;
                    rwidth_next[0] = width_reg;
                    cur_next       = 12'(pix_reg);
                    len_next       = 7'd1;
                    used_next      = used_n;
                    real_next      = real_n;
                    bytes_next     = bytes_n[15:0];
                    width_next     = width_n;
                    state_next     = S_EMIT;
                    if (restart)
                    begin
                        rcode_next[1]  = 12'(pix_reg);
                        rwidth_next[1] = width_n;
                        rcode_next[2]  = clear_code;
                        rwidth_next[2] = width_n;
                        lastidx_next   = 2'd2;
                        wipe_next      = 1'b1;
                        used_next      = '0;
                        real_next      = '0;
                        bytes_next     = 16'd1;
                        len_next       = '0;
                        width_next     = sw;
                    end
                    else
                    begin
                        lastidx_next = 2'd0;
                        wipe_next    = 1'b0;
                    end
                end
            end
            S_EMIT:
            begin
                res.valid = 1'b1;
                if (take)
                begin
                    if (idx_reg == lastidx_reg)
                    begin
                        state_next = wipe_reg ? S_CLEAR : S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            pbits_reg   <= 4'd8;
            cur_reg     <= '0;
            len_reg     <= '0;
            used_reg    <= '0;
            real_reg    <= '0;
            bytes_reg   <= 16'd1;
            width_reg   <= 4'd9;
            clr_reg     <= '0;
            idx_reg     <= '0;
            lastidx_reg <= '0;
            wipe_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            len_reg     <= len_next;
            used_reg    <= used_next;
            real_reg    <= real_next;
            bytes_reg   <= bytes_next;
            width_reg   <= width_next;
            clr_reg     <= clr_next;
            idx_reg     <= idx_next;
            lastidx_reg <= lastidx_next;
            wipe_reg    <= wipe_next;
            if (cfg_we)
            begin
                pbits_reg <= cfg_wdata;
            end
        end
    end

    // Payload: probe address, masked pixel and the result buffer.
    always_ff @(posedge clk)
    begin
        probe_reg  <= probe_next;
        pix_reg    <= pix_next;
        rcode_reg  <= rcode_next;
        rwidth_reg <= rwidth_next;
    end

    lpe_ram #(
        .WIDTH (ENTRY_W_L),
        .DEPTH (lpe_pkg::DICT_DEPTH)
    ) u_dict (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ((state_reg == S_CLEAR) ? {ENTRY_W_L{1'b0}} : wr_entry),
        .re    (ram_re),
        .raddr (probe_reg),
        .rdata (rd_data)
    );

    lpe_out_reg u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .res   (res),
        .take  (take),
        .codes (codes)
    );

endmodule
